// ===== rtl/tbps_pkg.sv =====
// ----------------------------------------------------------------------------
// tbps_pkg
// types and constants shared by the toggle-button power synchronizer
// ----------------------------------------------------------------------------
`default_nettype none

package tbps_pkg;

	localparam int unsigned TICK_W    = 16;
	localparam int unsigned SPEED_W   = 8;
	localparam int unsigned CFG_W     = 15;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 16;

	localparam logic [CFG_W-1:0] HOLD_RESET  = 15'd3663;
	localparam logic [CFG_W-1:0] PRESS_RESET = 15'd122;

	localparam logic [SPEED_W-1:0] PWM_TOP = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD  = 1'b0,
		REG_PRESS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [TICK_W-1:0]  now_tick;
		logic               led_lit;
		logic [SPEED_W-1:0] fan_speed;
	} item_t;

	typedef struct packed {
		logic               unit_powered;
		logic               button_out;
		logic [SPEED_W-1:0] pwm_compare;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/tbps_core.sv =====
// ----------------------------------------------------------------------------
// tbps_core
// config registers, power judgement and button timing state for one item
// ----------------------------------------------------------------------------
`default_nettype none

module tbps_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [tbps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tbps_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          step,
	input  wire tbps_pkg::item_t               item,
	output tbps_pkg::result_t                  result
);
	import tbps_pkg::*;

	logic [CFG_W-1:0]   hold_q;
	logic [CFG_W-1:0]   press_q;
	logic [TICK_W-1:0]  last_lit_q;
	logic [TICK_W-1:0]  last_action_q;
	logic               pressing_q;
	logic [SPEED_W-1:0] speed_q;

	logic [TICK_W-1:0]  lit_diff;
	logic [TICK_W-1:0]  since;
	logic [TICK_W:0]    holdoff;
	logic               dark_expired;
	logic               powered;
	logic [TICK_W-1:0]  last_lit_d;
	logic               pressing_d;
	logic               action;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= HOLD_RESET;
			press_q <= PRESS_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HOLD:  hold_q  <= cfg_data;
				REG_PRESS: press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// power judgement
	always_comb begin
		lit_diff     = item.now_tick - last_lit_q;
		dark_expired = lit_diff >= {1'b0, hold_q};
		powered      = item.led_lit || !dark_expired;
		if (item.led_lit) begin
			last_lit_d = item.now_tick;
		end else if (dark_expired) begin
			last_lit_d = item.now_tick - {1'b0, hold_q};
		end else begin
			last_lit_d = last_lit_q;
		end
	end

	// button timing
	always_comb begin
		since      = item.now_tick - last_action_q;
		holdoff    = {2'b00, hold_q} + {2'b00, press_q};
		pressing_d = pressing_q;
		action     = 1'b0;
		if (pressing_q) begin
			if ({1'b0, since} > {2'b00, press_q}) begin
				pressing_d = 1'b0;
				action     = 1'b1;
			end
		end else if ({1'b0, since} > holdoff && (powered != (speed_q != '0))) begin
			pressing_d = 1'b1;
			action     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_lit_q    <= '0;
			last_action_q <= '0;
			pressing_q    <= 1'b0;
			speed_q       <= '0;
		end else if (step) begin
			last_lit_q <= last_lit_d;
			pressing_q <= pressing_d;
			speed_q    <= item.fan_speed;
			if (action) begin
				last_action_q <= item.now_tick;
			end
		end
	end

	assign result.unit_powered = powered;
	assign result.button_out   = pressing_d;
	assign result.pwm_compare  = PWM_TOP - item.fan_speed;

endmodule

`default_nettype wire

// ===== rtl/toggle_button_power_sync.sv =====
// ----------------------------------------------------------------------------
// toggle_button_power_sync
// judges unit power from the status LED and drives a toggle button to match
// the requested fan speed, with PWM compare output
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    now_tick, led_lit, fan_speed
// m_axis    out  m_axis_tvalid/tready    unit_powered, button_out, pwm_compare
// cfg       in   cfg_wen                 hold_ticks (0), press_ticks (1)
//
// one transaction per cycle while m_axis_tready does not stall the result
// input register feeds the state update, result register holds the output
// state advances when the input register moves into the result register
// a stalled result holds both registers; ready drops only when both are full
// reset clears config to defaults and all timing state to zero
// ----------------------------------------------------------------------------
`default_nettype none

module toggle_button_power_sync (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [tbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tbps_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           s_axis_tvalid,
	output      logic                           s_axis_tready,
	// [15:0] now_tick, [16] led_lit, [24:17] fan_speed, [31:25] zero
	input  wire logic [tbps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output      logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// [0] unit_powered, [1] button_out, [9:2] pwm_compare, [15:10] zero
	output      logic [tbps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tbps_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    adv_s2;
	logic    take_s1;

	assign adv_s2        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign take_s1       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			item_s1.now_tick  <= s_axis_tdata[TICK_W-1:0];
			item_s1.led_lit   <= s_axis_tdata[TICK_W];
			item_s1.fan_speed <= s_axis_tdata[TICK_W+SPEED_W:TICK_W+1];
		end
	end

	tbps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (adv_s2),
		.item      (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		{(OUT_DATA_W - SPEED_W - 2){1'b0}},
		result_s2.pwm_compare,
		result_s2.button_out,
		result_s2.unit_powered
	};

endmodule

`default_nettype wire
